>>> design/spq_pkg.sv
package spq_pkg;

  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int PRIO_WIDTH  = 16;
  localparam int CNT_W       = $clog2(DEPTH + 1);

  typedef logic [VALUE_WIDTH-1:0]       value_t;
  typedef logic signed [PRIO_WIDTH-1:0] prio_t;
  typedef logic [CNT_W-1:0]             count_t;

  // Command codes on the input channel
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // Operation broadcast to every cell in a cycle
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE,
    OP_CLEAR
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    prio_t    prio;
    value_t   value;
  } cell_ctl_t;

endpackage

>>> design/sorted_priority_queue_top.sv
// Sorted priority queue of DEPTH (16) entries built as a row of shift cells.
// Each cell holds one (priority, value) pair; the head sits in cell 0 and the
// row stays sorted by descending signed priority, with equal priorities kept
// first in, first out. An insert compares the new priority against every cell
// at once: cells with an equal or higher priority hold, the first lower cell
// takes the new pair and the rest shift one place toward the tail. A remove
// shifts every cell one place toward the head and returns the old head value.
// A clear drops all entries at once. Every command (insert, remove, clear,
// or the unused code, which is ignored) yields exactly one result item with a
// status, the entry count after the command and an empty flag. One item is
// taken per clock cycle while in_stall is low; the result register lets a new
// item enter while the previous result is still waiting, as long as that
// result is taken in the same cycle.
// Insert on a full queue is refused with a full status; remove on an empty
// queue returns value zero with an empty status.
module sorted_priority_queue_top (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic signed [15:0] prio_level,
  input  logic [31:0] item_value,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] removed_value,
  output logic [1:0]  status,
  output logic [4:0]  entry_count,
  output logic        is_empty
);

  localparam int DEPTH = spq_pkg::DEPTH;

  logic                accept;
  logic                full;
  spq_pkg::count_t     held_count;
  spq_pkg::count_t     held_count_next;
  spq_pkg::cell_ctl_t  ctl;
  spq_pkg::status_t    stat_next;
  logic [31:0]         removed_next;

  logic [DEPTH-1:0]    cell_valid;
  logic [DEPTH-1:0]    cell_keep;
  spq_pkg::prio_t      cell_prio  [DEPTH];
  spq_pkg::value_t     cell_value [DEPTH];

  // Stall the input only while a result waits and the consumer is stalling.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (held_count == spq_pkg::count_t'(DEPTH));

  // Decode the command into a cell operation, the new count and the result.
  always_comb begin
    ctl.op          = spq_pkg::OP_HOLD;
    ctl.prio        = prio_level;
    ctl.value       = spq_pkg::value_t'(item_value);
    held_count_next = held_count;
    stat_next       = spq_pkg::STAT_OK;
    removed_next    = '0;
    case (spq_pkg::cmd_t'(cmd))
      spq_pkg::CMD_INSERT: begin
        if (full) begin
          stat_next = spq_pkg::STAT_FULL;
        end else begin
          ctl.op          = spq_pkg::OP_INSERT;
          held_count_next = held_count + spq_pkg::count_t'(1);
        end
      end
      spq_pkg::CMD_REMOVE: begin
        if (held_count == '0) begin
          stat_next = spq_pkg::STAT_EMPTY;
        end else begin
          ctl.op          = spq_pkg::OP_REMOVE;
          held_count_next = held_count - spq_pkg::count_t'(1);
          removed_next    = 32'(cell_value[0]);
        end
      end
      spq_pkg::CMD_CLEAR: begin
        ctl.op          = spq_pkg::OP_CLEAR;
        held_count_next = '0;
      end
      default: begin
        // unused code: hold the queue, report ok
      end
    endcase
    if (!accept) begin
      ctl.op = spq_pkg::OP_HOLD;
    end
  end

  // Cell row: each cell sees its head-side and tail-side neighbor.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic            pv_valid;
    logic            pv_keep;
    spq_pkg::prio_t  pv_prio;
    spq_pkg::value_t pv_value;
    logic            nx_valid;
    spq_pkg::prio_t  nx_prio;
    spq_pkg::value_t nx_value;

    if (i == 0) begin : g_head
      assign pv_valid = 1'b1;
      assign pv_keep  = 1'b1;
      assign pv_prio  = '0;
      assign pv_value = '0;
    end else begin : g_mid
      assign pv_valid = cell_valid[i-1];
      assign pv_keep  = cell_keep[i-1];
      assign pv_prio  = cell_prio[i-1];
      assign pv_value = cell_value[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign nx_valid = 1'b0;
      assign nx_prio  = '0;
      assign nx_value = '0;
    end else begin : g_body
      assign nx_valid = cell_valid[i+1];
      assign nx_prio  = cell_prio[i+1];
      assign nx_value = cell_value[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .prev_valid (pv_valid),
      .prev_keep  (pv_keep),
      .prev_prio  (pv_prio),
      .prev_value (pv_value),
      .next_valid (nx_valid),
      .next_prio  (nx_prio),
      .next_value (nx_value),
      .valid      (cell_valid[i]),
      .keep       (cell_keep[i]),
      .prio       (cell_prio[i]),
      .value      (cell_value[i])
    );
  end

  // Count and result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        held_count <= held_count_next;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload: load on accept, hold otherwise.
  always_ff @(posedge clk) begin
    if (accept) begin
      removed_value <= removed_next;
      status        <= stat_next;
      entry_count   <= 5'(held_count_next);
      is_empty      <= (held_count_next == '0);
    end
  end

`ifndef ASSERT_OFF
  // Occupied cells always form a prefix from the head.
  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    ((cell_valid + 1'b1) & cell_valid) == '0)
    else $error("cell occupancy is not a prefix");

  // Count matches occupied cells.
  a_count_match: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == int'(held_count))
    else $error("held count disagrees with cell occupancy");

  // Head two entries are in priority order.
  a_head_order: assert property (@(posedge clk) disable iff (rst)
    cell_valid[1] |-> (cell_prio[0] >= cell_prio[1]))
    else $error("head entries out of priority order");

  // A refused insert leaves a full queue.
  a_full_report: assert property (@(posedge clk) disable iff (rst)
    accept && (stat_next == spq_pkg::STAT_FULL) |=> full && cell_valid[DEPTH-1])
    else $error("full status without a full queue");

  // An empty status result carries zero value and zero count.
  a_empty_report: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == spq_pkg::STAT_EMPTY) |->
      (removed_value == '0) && (entry_count == '0) && is_empty)
    else $error("empty status with nonzero value or count");
`endif

endmodule

>>> design/spq_cell.sv
module spq_cell (
  input  logic               clk,
  input  logic               rst,
  input  spq_pkg::cell_ctl_t ctl,
  // neighbor toward the head
  input  logic               prev_valid,
  input  logic               prev_keep,
  input  spq_pkg::prio_t     prev_prio,
  input  spq_pkg::value_t    prev_value,
  // neighbor toward the tail
  input  logic               next_valid,
  input  spq_pkg::prio_t     next_prio,
  input  spq_pkg::value_t    next_value,
  output logic               valid,
  output logic               keep,
  output spq_pkg::prio_t     prio,
  output spq_pkg::value_t    value
);

  // Stay in place on insert when holding an equal or higher priority.
  assign keep = valid && (prio >= ctl.prio);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (ctl.op)
        spq_pkg::OP_INSERT: valid <= valid | prev_valid;
        spq_pkg::OP_REMOVE: valid <= next_valid;
        spq_pkg::OP_CLEAR:  valid <= 1'b0;
        default:            valid <= valid;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      spq_pkg::OP_INSERT: begin
        if (!keep) begin
          if (prev_keep) begin
            prio  <= ctl.prio;
            value <= ctl.value;
          end else begin
            prio  <= prev_prio;
            value <= prev_value;
          end
        end
      end
      spq_pkg::OP_REMOVE: begin
        prio  <= next_prio;
        value <= next_value;
      end
      default: begin
        prio  <= prio;
        value <= value;
      end
    endcase
  end

endmodule
